FILE: design/vag_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the VAG ADPCM block decoder.
// Used by vag_ctrl, vag_dpath and vag_adpcm_block_decoder; no dependencies.
package vag_pkg;

  localparam int SAMPLES_PER_BLOCK = 28;
  localparam int CNT_BITS          = 5;
  localparam int NIB_BITS          = 112;

  // Block flag codes
  localparam logic [7:0] FLAG_LOOP_START = 8'h06;
  localparam logic [7:0] FLAG_LOOP_END   = 8'h03;
  localparam logic [7:0] FLAG_END_DATA   = 8'h07;

  localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;

  // Bit positions inside tuser
  localparam int IN_USER_FIRST  = 0;
  localparam int OUT_USER_VALID = 0;
  localparam int OUT_USER_LSF   = 1;
  localparam int OUT_USER_LEF   = 2;
  localparam int OUT_USER_DONE  = 3;

  typedef struct packed {
    logic signed [7:0] c1;
    logic signed [7:0] c2;
  } coef_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;        // first block: wipe history, position, marks, done
    logic load;         // latch the block header and data
    logic step;         // decode one sample into the output register
    logic last_sample;  // the sample being stepped is the block's 28th
    logic emit_end;     // emit the sampleless end-of-sound result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;         // sound has ended
    logic out_free;     // output register can take a result this cycle
  } status_t;

  function automatic coef_t coef_lookup(input logic [3:0] filt);
    coef_t c;
    begin
      unique case (filt)
        4'd1:    c = '{c1: 8'sd60,  c2: 8'sd0};
        4'd2:    c = '{c1: 8'sd115, c2: -8'sd52};
        4'd3:    c = '{c1: 8'sd98,  c2: -8'sd55};
        4'd4:    c = '{c1: 8'sd122, c2: -8'sd60};
        default: c = '{c1: 8'sd0,   c2: 8'sd0};
      endcase
      return c;
    end
  endfunction

endpackage

FILE: design/vag_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the VAG ADPCM block decoder.
// Depends on vag_pkg for the command and status structs.
module vag_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_first,
  input  logic             in_end_kind,
  input  vag_pkg::status_t status,
  output logic             in_tready,
  output vag_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_END  = 3'b100
  } state_t;

  localparam logic [vag_pkg::CNT_BITS-1:0] CNT_LAST =
    vag_pkg::CNT_BITS'(vag_pkg::SAMPLES_PER_BLOCK - 1);

  state_t                        state_r, state_nxt;
  logic [vag_pkg::CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                          accept;
  logic                          skip;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  // a block after the sound ended is dropped unless it starts a new sound
  assign skip      = status.done && !in_first;

  always_comb begin
    cmd.clear       = accept && in_first;
    cmd.load        = accept && !skip;
    cmd.step        = (state_r == S_RUN) && status.out_free;
    cmd.last_sample = (cnt_r == CNT_LAST);
    cmd.emit_end    = (state_r == S_END) && status.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          cnt_nxt   = '0;
          state_nxt = in_end_kind ? S_END : S_RUN;
        end
      end
      S_RUN: begin
        if (cmd.step) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cmd.last_sample) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_END: begin
        if (cmd.emit_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_load_to_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && !in_end_kind |=> state_r == S_RUN)
    else $error("decoded block did not start the sample run");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) && cmd.step && cmd.last_sample |=> state_r == S_IDLE)
    else $error("sample run did not stop after the last sample");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> cnt_r <= CNT_LAST)
    else $error("sample counter ran past the block length");
`endif

endmodule

FILE: design/vag_dpath.sv
`timescale 1ns / 1ps
// Datapath of the VAG ADPCM block decoder: history, predictor, clamp,
// position and loop marks, and the output register. Depends on vag_pkg.
module vag_dpath #(
  parameter int POSITION_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vag_pkg::cmd_t                  cmd,
  output vag_pkg::status_t               status,
  input  logic [3:0]                     in_shift_amount,
  input  logic [3:0]                     in_filter_select,
  input  logic [7:0]                     in_block_flag,
  input  logic [vag_pkg::NIB_BITS-1:0]   in_nibbles,
  input  logic                           in_final_block,
  input  logic                           out_tready,
  output logic                           out_valid,
  output logic signed [15:0]             out_sample,
  output logic                           out_sample_valid,
  output logic [23:0]                    out_sample_position,
  output logic [23:0]                    out_loop_start,
  output logic                           out_loop_start_found,
  output logic [23:0]                    out_loop_end,
  output logic                           out_loop_end_found,
  output logic                           out_sound_done,
  output logic                           out_last
);

  localparam logic [POSITION_BITS-1:0] BLOCK_LEN =
    POSITION_BITS'(vag_pkg::SAMPLES_PER_BLOCK);

  // State
  logic signed [15:0]           h1_r, h1_nxt, h2_r, h2_nxt;
  logic [POSITION_BITS-1:0]     pos_r, pos_nxt, mark_r, mark_nxt;
  logic                         seen_r, seen_nxt, done_r, done_nxt;
  // Block payload
  logic [3:0]                   shift_r;
  vag_pkg::coef_t               coef_r;
  logic [vag_pkg::NIB_BITS-1:0] nib_sr_r;
  logic                         fin_r, loop_end_kind_r;
  // Output register
  logic                         ov_r, ov_nxt;
  logic signed [15:0]           o_sample_r;
  logic                         o_svalid_r, o_lsf_r, o_lef_r, o_done_r, o_last_r;
  logic [POSITION_BITS-1:0]     o_pos_r, o_ls_r, o_le_r;

  // Predictor and sample arithmetic
  logic signed [23:0]           p1, p2;
  logic signed [24:0]           psum;
  logic signed [18:0]           pred;
  logic signed [3:0]            nib;
  logic signed [19:0]           nib_sh;
  logic signed [20:0]           s_wide;
  logic signed [15:0]           s_clamp;
  logic [POSITION_BITS-1:0]     pos_base, pos_inc;
  logic                         seen_base;
  logic                         fin_hit;

  assign p1     = coef_r.c1 * h1_r;
  assign p2     = coef_r.c2 * h2_r;
  assign psum   = 25'(p1) + 25'(p2) + 25'sd32;
  assign pred   = 19'(psum >>> 6);
  assign nib    = nib_sr_r[vag_pkg::NIB_BITS-1 -: 4];
  assign nib_sh = 20'(nib) <<< shift_r;
  assign s_wide = 21'(nib_sh) + 21'(pred);

  always_comb begin
    priority if (s_wide < 21'(vag_pkg::SAMPLE_MIN)) begin
      s_clamp = vag_pkg::SAMPLE_MIN;
    end else if (s_wide > 21'(vag_pkg::SAMPLE_MAX)) begin
      s_clamp = vag_pkg::SAMPLE_MAX;
    end else begin
      s_clamp = s_wide[15:0];
    end
  end

  assign pos_base  = cmd.clear ? '0 : pos_r;
  assign seen_base = cmd.clear ? 1'b0 : seen_r;
  assign pos_inc   = pos_r + 1'b1;
  assign fin_hit   = cmd.last_sample && fin_r;

  always_comb begin
    h1_nxt   = h1_r;
    h2_nxt   = h2_r;
    pos_nxt  = pos_r;
    mark_nxt = mark_r;
    seen_nxt = seen_r;
    done_nxt = done_r;
    if (cmd.clear) begin
      h1_nxt   = '0;
      h2_nxt   = '0;
      pos_nxt  = '0;
      mark_nxt = '0;
      seen_nxt = 1'b0;
      done_nxt = 1'b0;
    end
    if (cmd.load && (in_block_flag == vag_pkg::FLAG_LOOP_START)) begin
      // loop start sits one block back, floored at zero
      mark_nxt = (pos_base >= BLOCK_LEN) ? pos_base - BLOCK_LEN : '0;
      seen_nxt = 1'b1;
    end else if (cmd.load) begin
      seen_nxt = seen_base;
    end
    if (cmd.step) begin
      h2_nxt  = h1_r;
      h1_nxt  = s_clamp;
      pos_nxt = pos_inc;
      if (fin_hit) begin
        done_nxt = 1'b1;
      end
    end
    if (cmd.emit_end) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r   <= '0;
      h2_r   <= '0;
      pos_r  <= '0;
      mark_r <= '0;
      seen_r <= 1'b0;
      done_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      h1_r   <= h1_nxt;
      h2_r   <= h2_nxt;
      pos_r  <= pos_nxt;
      mark_r <= mark_nxt;
      seen_r <= seen_nxt;
      done_r <= done_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Block payload: latch on load, shift one nibble out per sample
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shift_r         <= in_shift_amount;
      coef_r          <= vag_pkg::coef_lookup(in_filter_select);
      nib_sr_r        <= in_nibbles;
      fin_r           <= in_final_block;
      loop_end_kind_r <= (in_block_flag == vag_pkg::FLAG_LOOP_END);
    end else if (cmd.step) begin
      nib_sr_r <= {nib_sr_r[vag_pkg::NIB_BITS-5:0], 4'h0};
    end
  end

  assign status.done     = done_r;
  assign status.out_free = !ov_r || out_tready;

  always_comb begin
    ov_nxt = ov_r;
    if (cmd.step || cmd.emit_end) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      o_sample_r <= s_clamp;
      o_svalid_r <= 1'b1;
      o_pos_r    <= pos_r;
      o_ls_r     <= seen_r ? mark_r : '0;
      o_lsf_r    <= seen_r;
      o_lef_r    <= fin_hit && seen_r;
      o_le_r     <= (fin_hit && seen_r) ? pos_inc : '0;
      o_done_r   <= fin_hit;
      o_last_r   <= cmd.last_sample;
    end else if (cmd.emit_end) begin
      o_sample_r <= '0;
      o_svalid_r <= 1'b0;
      o_pos_r    <= pos_r;
      o_ls_r     <= seen_r ? mark_r : '0;
      o_lsf_r    <= seen_r;
      o_lef_r    <= loop_end_kind_r || seen_r;
      o_le_r     <= (loop_end_kind_r || seen_r) ? pos_r : '0;
      o_done_r   <= 1'b1;
      o_last_r   <= 1'b1;
    end
  end

  // Present positions as 24 bits whatever the counter width
  logic [POSITION_BITS+23:0] pos_ext, ls_ext, le_ext;
  assign pos_ext = {24'h0, o_pos_r};
  assign ls_ext  = {24'h0, o_ls_r};
  assign le_ext  = {24'h0, o_le_r};

  assign out_valid            = ov_r;
  assign out_sample           = o_sample_r;
  assign out_sample_valid     = o_svalid_r;
  assign out_sample_position  = pos_ext[23:0];
  assign out_loop_start       = ls_ext[23:0];
  assign out_loop_start_found = o_lsf_r;
  assign out_loop_end         = le_ext[23:0];
  assign out_loop_end_found   = o_lef_r;
  assign out_sound_done       = o_done_r;
  assign out_last             = o_last_r;

endmodule

FILE: design/vag_adpcm_block_decoder.sv
`timescale 1ns / 1ps
// Top level of the VAG ADPCM block decoder: stream ports, controller and datapath.
// Depends on vag_pkg, vag_ctrl and vag_dpath.
//
// One input item is a 16-byte VAG ADPCM block; it yields 28 sample items, one
// per nibble (high nibble first), or a single sampleless item when its flag ends
// the sound (loop end or end of data). Once a block is accepted, its results
// follow one per cycle while the output side is ready; the rate is set by the
// prediction loop, in which each sample needs the previous two clamped samples.
// in_tready is high whenever no block is being decoded, even if the last result
// still waits in the output register. After a sound has ended, blocks are dropped
// without results until one arrives with the first-block bit set. Positions count
// modulo 2^POSITION_BITS and are shown in 24 bits.
module vag_adpcm_block_decoder #(
  parameter int POSITION_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  // Block input
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // shift_amount[3:0], filter_select[7:4],
                                   // data_high[63:8], data_low[119:64]
  input  logic [8:0]   in_tuser,   // first_block[0], block_flag[8:1]
  input  logic         in_tlast,   // final_block
  // Sample output
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // sample[15:0], sample_position[39:16],
                                   // loop_start[63:40], loop_end[87:64]
  output logic [3:0]   out_tuser,  // sample_valid[0], loop_start_found[1],
                                   // loop_end_found[2], sound_done[3]
  output logic         out_tlast   // last
);

  vag_pkg::cmd_t    cmd;
  vag_pkg::status_t status;

  logic [7:0]  block_flag;
  logic        end_kind;

  logic signed [15:0] sample;
  logic [23:0] sample_position, loop_start, loop_end;
  logic        sample_valid, loop_start_found, loop_end_found, sound_done;

  assign block_flag = in_tuser[8:1];
  // loop end and end of data both stop the sound without decoding samples
  assign end_kind   = (block_flag == vag_pkg::FLAG_LOOP_END) ||
                      (block_flag == vag_pkg::FLAG_END_DATA);

  vag_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_first    (in_tuser[vag_pkg::IN_USER_FIRST]),
    .in_end_kind (end_kind),
    .status      (status),
    .in_tready   (in_tready),
    .cmd         (cmd)
  );

  vag_dpath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_shift_amount      (in_tdata[3:0]),
    .in_filter_select     (in_tdata[7:4]),
    .in_block_flag        (block_flag),
    .in_nibbles           ({in_tdata[63:8], in_tdata[119:64]}),
    .in_final_block       (in_tlast),
    .out_tready           (out_tready),
    .out_valid            (out_tvalid),
    .out_sample           (sample),
    .out_sample_valid     (sample_valid),
    .out_sample_position  (sample_position),
    .out_loop_start       (loop_start),
    .out_loop_start_found (loop_start_found),
    .out_loop_end         (loop_end),
    .out_loop_end_found   (loop_end_found),
    .out_sound_done       (sound_done),
    .out_last             (out_tlast)
  );

  // Pack result fields, lowest field first
  assign out_tdata = {loop_end, loop_start, sample_position, sample};
  assign out_tuser = {sound_done, loop_end_found, loop_start_found, sample_valid};

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for vag_adpcm_block_decoder: drives ADPCM blocks, predicts
// the decoded PCM items in-bench and compares them field by field. Needs vag_pkg.
module tb_top;

  localparam int N_RANDOM    = 300;   // random blocks that produce items
  localparam int LONG_HOLD   = 300;   // sink hold-off, in cycles
  localparam int STUCK_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_WAIT  = 40;    // settle time once nothing is pending

  // Predictor taps per filter; filters 5..15 fall back to zero taps
  localparam int TAP_NEW[5] = '{0, 60, 115, 98, 122};
  localparam int TAP_OLD[5] = '{0, 0, -52, -55, -60};

  typedef struct packed {
    logic        first;
    logic [3:0]  shift;
    logic [3:0]  filt;
    logic [7:0]  flag;
    logic [55:0] data_high;
    logic [55:0] data_low;
    logic        fin;
  } adpcm_block_t;

  typedef struct packed {
    logic [15:0] smp;
    logic        vld;
    logic [23:0] pos;
    logic [23:0] lstart;
    logic        lsf;
    logic [23:0] lend;
    logic        lef;
    logic        done;
    logic        last;
  } pcm_result_t;

  // Directed row: a block plus, where obvious, the first sample and the
  // flag bits {done, lef, lsf, valid} of the block's last item
  typedef struct packed {
    adpcm_block_t blk;
    logic         typed;
    logic [15:0]  t_smp;
    logic [3:0]   t_user;
  } stim_entry_t;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata   = '0;
  logic [8:0]   in_tuser   = '0;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [87:0]  out_tdata;
  logic [3:0]   out_tuser;
  logic         out_tlast;

  // Bench-side copy of the decoder state
  int          hist_new, hist_old;
  logic [23:0] pos_cnt, loop_mark;
  logic        loop_seen, sound_over;

  pcm_result_t block_out[$];    // items produced by the block just accepted
  pcm_result_t pending_pcm[$];  // items still awaited from the DUT
  stim_entry_t dir_rows[$];

  int errors       = 0;
  int stuck_cycles = 0;
  bit idle_on      = 1'b1;
  bit hold_req     = 1'b0;

  vag_adpcm_block_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Decode one block into block_out; return how many PCM items it yields
  function automatic int decode_block(adpcm_block_t b);
    int               c_new, c_old, smp, k;
    logic signed [3:0] code;
    logic [111:0]     nibs;
    pcm_result_t      r;
    block_out.delete();
    if (b.first) begin
      hist_new   = 0;
      hist_old   = 0;
      pos_cnt    = '0;
      loop_mark  = '0;
      loop_seen  = 1'b0;
      sound_over = 1'b0;
    end
    // Drop blocks once the sound has ended
    if (sound_over) return 0;
    if (b.flag == vag_pkg::FLAG_LOOP_START) begin
      loop_mark = (pos_cnt >= 24'(vag_pkg::SAMPLES_PER_BLOCK)) ?
                  pos_cnt - 24'(vag_pkg::SAMPLES_PER_BLOCK) : '0;
      loop_seen = 1'b1;
    end
    // Ending flags give one item without a sample
    if (b.flag == vag_pkg::FLAG_LOOP_END || b.flag == vag_pkg::FLAG_END_DATA) begin
      sound_over = 1'b1;
      r        = '0;
      r.pos    = pos_cnt;
      r.lsf    = loop_seen;
      r.lstart = loop_seen ? loop_mark : '0;
      r.lef    = (b.flag == vag_pkg::FLAG_LOOP_END) || loop_seen;
      r.lend   = r.lef ? pos_cnt : '0;
      r.done   = 1'b1;
      r.last   = 1'b1;
      block_out.insert(block_out.size(), r);
      return 1;
    end
    c_new = (b.filt < 5) ? TAP_NEW[b.filt] : 0;
    c_old = (b.filt < 5) ? TAP_OLD[b.filt] : 0;
    nibs  = {b.data_high, b.data_low};
    for (k = 0; k < vag_pkg::SAMPLES_PER_BLOCK; k++) begin
      code = nibs[111 - 4 * k -: 4];
      smp  = int'(code) * (1 << b.shift) +
             ((c_new * hist_new + c_old * hist_old + 32) >>> 6);
      if (smp < int'(vag_pkg::SAMPLE_MIN)) smp = int'(vag_pkg::SAMPLE_MIN);
      if (smp > int'(vag_pkg::SAMPLE_MAX)) smp = int'(vag_pkg::SAMPLE_MAX);
      hist_old = hist_new;
      hist_new = smp;
      r        = '0;
      r.smp    = smp[15:0];
      r.vld    = 1'b1;
      r.pos    = pos_cnt;
      r.lsf    = loop_seen;
      r.lstart = loop_seen ? loop_mark : '0;
      r.last   = (k == vag_pkg::SAMPLES_PER_BLOCK - 1);
      pos_cnt  = pos_cnt + 1'b1;
      if (r.last && b.fin) begin
        sound_over = 1'b1;
        r.lef  = loop_seen;
        r.lend = loop_seen ? pos_cnt : '0;
        r.done = 1'b1;
      end
      block_out.insert(block_out.size(), r);
    end
    return vag_pkg::SAMPLES_PER_BLOCK;
  endfunction

  function automatic stim_entry_t stim(logic first, logic [3:0] shift, logic [3:0] filt,
                                       logic [7:0] flag, logic [55:0] dh, logic [55:0] dl,
                                       logic fin, logic typed = 1'b0,
                                       logic [15:0] t_smp = '0, logic [3:0] t_user = '0);
    stim_entry_t e;
    e.blk   = '{first: first, shift: shift, filt: filt, flag: flag,
                data_high: dh, data_low: dl, fin: fin};
    e.typed  = typed;
    e.t_smp  = t_smp;
    e.t_user = t_user;
    return e;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(stim_entry_t e);
    dir_rows.insert(dir_rows.size(), e);
  endfunction

  // Random block with an ordinary flag; loop start now and then
  function automatic adpcm_block_t rand_block();
    adpcm_block_t b;
    b.first     = 1'b0;
    b.shift     = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 11)) : 4'($urandom);
    b.filt      = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 4)) : 4'($urandom);
    b.flag      = 8'($urandom);
    if (b.flag == vag_pkg::FLAG_LOOP_END || b.flag == vag_pkg::FLAG_END_DATA) begin
      b.flag = b.flag ^ 8'h10;
    end
    if ($urandom_range(0, 7) == 0) b.flag = vag_pkg::FLAG_LOOP_START;
    b.data_high = 56'({$urandom, $urandom});
    b.data_low  = 56'({$urandom, $urandom});
    b.fin       = 1'b0;
    return b;
  endfunction

  // Offer one block, hold it until taken, then queue its predicted items.
  task automatic send_block(input stim_entry_t e, output int n_res);
    int          gap;
    pcm_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {e.blk.data_low, e.blk.data_high, e.blk.filt, e.blk.shift};
    in_tuser  <= {e.blk.flag, e.blk.first};
    in_tlast  <= e.blk.fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_res = decode_block(e.blk);
    // Typed rows replace the prediction for the fields read off by hand
    if (e.typed && n_res > 0) begin
      r = block_out[0];
      r.smp = e.t_smp;
      block_out[0] = r;
      r = block_out[n_res - 1];
      {r.done, r.lef, r.lsf, r.vld} = e.t_user;
      block_out[n_res - 1] = r;
    end
    foreach (block_out[i]) pending_pcm.insert(pending_pcm.size(), block_out[i]);
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compare every accepted output item with the oldest pending prediction
  always @(posedge clk) begin
    pcm_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.smp    = out_tdata[15:0];
      got.pos    = out_tdata[39:16];
      got.lstart = out_tdata[63:40];
      got.lend   = out_tdata[87:64];
      got.vld    = out_tuser[vag_pkg::OUT_USER_VALID];
      got.lsf    = out_tuser[vag_pkg::OUT_USER_LSF];
      got.lef    = out_tuser[vag_pkg::OUT_USER_LEF];
      got.done   = out_tuser[vag_pkg::OUT_USER_DONE];
      got.last   = out_tlast;
      if (pending_pcm.size() == 0) begin
        $error("unexpected output item: sample %0d at position %0d",
               $signed(got.smp), got.pos);
        errors++;
      end else begin
        want = pending_pcm.pop_front();
        check_field("sample", $signed(want.smp), $signed(got.smp));
        check_field("sample_valid", want.vld, got.vld);
        check_field("sample_position", want.pos, got.pos);
        check_field("loop_start", want.lstart, got.lstart);
        check_field("loop_start_found", want.lsf, got.lsf);
        check_field("loop_end", want.lend, got.lend);
        check_field("loop_end_found", want.lef, got.lef);
        check_field("sound_done", want.done, got.done);
        check_field("last", want.last, got.last);
      end
    end
  end

  // Watchdog: abort when no handshake happens on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Sink: random stall bursts, plus one long hold-off on request
  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Source: directed table first, then randomized sounds
  initial begin : source_side
    int          n_res, rand_items, n_blk, ending, sound_no, j;
    stim_entry_t e;

    // first, shift, filter, flag, data_high, data_low, final[, typed, sample, flags]
    // Silence right after reset
    add_row(stim(1, 0, 0, 8'h00, '0, '0, 0, 1, 16'sd0, 4'b0001));
    // Full-scale positive and negative nibbles at the largest shift: clamp
    add_row(stim(0, 15, 0, 8'h00, 56'h77777777777777, 56'h77777777777777, 0,
                 1, 16'h7fff, 4'b0001));
    add_row(stim(0, 15, 0, 8'h00, 56'h88888888888888, 56'h88888888888888, 0,
                 1, 16'h8000, 4'b0001));
    // Unused filter: zero taps, so each nibble of one decodes to one
    add_row(stim(0, 0, 5, 8'h00, 56'h11111111111111, 56'h11111111111111, 0,
                 1, 16'sd1, 4'b0001));
    // Filters 1 to 4 and an unused one, at assorted shifts
    add_row(stim(0, 12, 1, 8'h02, 56'h0123456789abcd, 56'hef0123456789ab, 0));
    add_row(stim(0, 9, 2, 8'hff, 56'h7f80017e81fe02, 56'hc3a55a3c96690f, 0));
    add_row(stim(0, 10, 3, 8'h01, 56'h1f2e3d4c5b6a79, 56'h8897a6b5c4d3e2, 0));
    add_row(stim(0, 15, 4, 8'h00, 56'h7f7f7f7f7f7f7f, 56'h80808080808080, 0));
    add_row(stim(0, 0, 15, 8'h00, 56'hffffffffffffff, 56'hffffffffffffff, 0));
    // Loop start mid-sound, then end of data with the loop start known
    add_row(stim(0, 4, 2, vag_pkg::FLAG_LOOP_START,
                 56'h2468ace02468ac, 56'h13579bdf135790, 0));
    add_row(stim(0, 6, 4, 8'h00, 56'h0f1e2d3c4b5a69, 56'h78879687a5b4c3, 0));
    add_row(stim(0, 0, 0, vag_pkg::FLAG_END_DATA,
                 56'h55555555555555, 56'haaaaaaaaaaaaaa, 0));
    // Block after the sound ended: dropped
    add_row(stim(0, 3, 1, 8'h00, 56'h12345678123456, 56'h78123456781234, 0));
    // New sound opening with a loop start: mark floors at zero; then loop end
    add_row(stim(1, 2, 1, vag_pkg::FLAG_LOOP_START,
                 56'h9abcdef0123456, 56'h789abcdef01234, 0));
    add_row(stim(0, 5, 3, 8'h00, 56'h0011223344556f, 56'h778899aabbccdd, 0));
    add_row(stim(0, 0, 0, vag_pkg::FLAG_LOOP_END,
                 56'h00000000000000, 56'h00000000000000, 0));
    // Sounds that end at once, without and with a loop end
    add_row(stim(1, 0, 0, vag_pkg::FLAG_END_DATA, '0, '0, 0, 1, 16'sd0, 4'b1000));
    add_row(stim(1, 0, 0, vag_pkg::FLAG_LOOP_END, '0, '0, 0, 1, 16'sd0, 4'b1100));
    // Final block without a loop, then a dropped block
    add_row(stim(1, 8, 4, 8'h00, 56'h3c3c3c3c3c3c3c, 56'hc3c3c3c3c3c3c3, 1));
    add_row(stim(0, 1, 1, 8'h00, 56'h11111111111111, 56'h22222222222222, 0));
    // Final block after a loop start: loop end is the sample total
    add_row(stim(1, 3, 2, vag_pkg::FLAG_LOOP_START,
                 56'h76543210fedcba, 56'h98765432100123, 0));
    add_row(stim(0, 7, 3, 8'h5a, 56'hdeadbeefcafe12, 56'h3456789abcdef0, 1));
    // Prediction pushed to both rails
    add_row(stim(1, 15, 4, 8'h00, 56'h77777777777777, 56'h88888888888888, 0));
    add_row(stim(0, 15, 4, 8'h00, 56'h88888888888888, 56'h77777777777777, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_block(dir_rows[i], n_res);

    // Random sounds: mostly well-formed runs with random content, plus noise
    rand_items = 0;
    sound_no   = 0;
    while (rand_items < N_RANDOM) begin
      sound_no++;
      // Hold the sink off while blocks keep coming, so the input backs up
      if (sound_no == 4) hold_req = 1'b1;
      // Let everything drain before the next sound
      if (sound_no == 9) begin
        in_tvalid <= 1'b0;
        while (pending_pcm.size() != 0) @(posedge clk);
      end
      // No idling on either side for the last stretch
      if (rand_items > N_RANDOM - 60) idle_on = 1'b0;
      n_blk  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      ending = $urandom_range(0, 3);
      for (j = 0; j < n_blk; j++) begin
        e           = '0;
        e.blk       = rand_block();
        e.blk.first = (j == 0);
        if (j == n_blk - 1) begin
          unique case (ending)
            0:       e.blk.flag = vag_pkg::FLAG_LOOP_END;
            1:       e.blk.flag = vag_pkg::FLAG_END_DATA;
            2:       e.blk.fin  = 1'b1;
            default: ;
          endcase
        end
        send_block(e, n_res);
        if (n_res > 0) rand_items++;
      end
      // Noise: any flag, sometimes a restart, often dropped after an ending
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          e           = '0;
          e.blk       = rand_block();
          e.blk.flag  = 8'($urandom);
          e.blk.first = ($urandom_range(0, 7) == 0);
          e.blk.fin   = 1'($urandom_range(0, 1));
          send_block(e, n_res);
          if (n_res > 0) rand_items++;
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_pcm.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
